FILE: design/bht_pkg.sv
// Shared types, codes and constants for the bucketed hash table.
package bht_pkg;

  localparam int KEY_W            = 31;
  localparam int CMD_W            = 2;
  localparam int STATUS_W         = 3;
  localparam int BUCKET_OUT_W     = 8;
  localparam int SLOT_OUT_W       = 6;
  localparam int CFG_W            = 9;
  localparam int DEF_MAX_BUCKETS  = 256;
  localparam int DEF_SLOTS        = 64;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  // The spare command code behaves as a plain lookup.
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

  localparam logic [STATUS_W-1:0] STS_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] STS_ABSENT   = 3'd2;
  localparam logic [STATUS_W-1:0] STS_DELETED  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
  } bht_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [BUCKET_OUT_W-1:0] bucket_index;
    logic [SLOT_OUT_W-1:0]   slot_index;
  } bht_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_BASE, ST_SCAN, ST_DRAIN, ST_FINISH
  } bht_state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic div_step;
    logic base_load;
    logic scan_step;
    logic finish;
  } bht_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic scan_last;
    logic out_busy;
  } bht_sts_t;

endpackage

FILE: design/bucketed_hash_table.sv
// Top level of the bucketed hash table: controller plus datapath.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid/in_ready    bht_in_t  (command, key)
//   out_      output     out_valid/out_ready  bht_out_t (status, bucket, slot)
//   cfg_      input      cfg_we               cfg_data  (bucket count)
//
// Each item passes through load, the bit-serial modulo divider, a base step, the
// slot scan (one slot of the entry memory read per cycle), a drain step and finish.
// After reset a clearing pass writes every memory entry before the first transfer in.
// A new item is taken only once the last one has finished; a stalled result
// register holds the next item in its finish state only.
module bucketed_hash_table #(
  parameter int MAX_BUCKETS      = bht_pkg::DEF_MAX_BUCKETS,
  parameter int SLOTS_PER_BUCKET = bht_pkg::DEF_SLOTS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bht_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bht_pkg::bht_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bht_pkg::bht_out_t         out_data
);
  import bht_pkg::*;

  bht_cmd_t cmd;
  bht_sts_t sts;

  bht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bht_dp #(
    .MAX_BUCKETS      (MAX_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: design/bht_ctrl.sv
// Sequencing state machine for the bucketed hash table.
module bht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bht_pkg::bht_sts_t sts,
  output bht_pkg::bht_cmd_t cmd
);
  import bht_pkg::*;

  bht_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_BASE;
      end
      ST_BASE: begin
        cmd.base_load = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/bht_dp.sv
// Divider, entry memory, slot scan and result register of the hash table.
module bht_dp #(
  parameter int MAX_BUCKETS      = bht_pkg::DEF_MAX_BUCKETS,
  parameter int SLOTS_PER_BUCKET = bht_pkg::DEF_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bht_pkg::CFG_W-1:0]  cfg_data,
  input  bht_pkg::bht_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bht_pkg::bht_out_t          out_data,
  input  bht_pkg::bht_cmd_t          cmd,
  output bht_pkg::bht_sts_t          sts
);
  import bht_pkg::*;

  localparam int ENTRIES = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW      = $clog2(MAX_BUCKETS + 1);
  localparam int SCW     = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int DCW     = $clog2(KEY_W);
  localparam int MW      = KEY_W + 1;

  logic [MW-1:0]    mem [ENTRIES];
  logic [CFG_W-1:0] cfg_r;
  logic [AW-1:0]    clr_addr_r;
  logic [CMD_W-1:0] cmd_r;
  logic [KEY_W-1:0] key_r, ksh_r;
  logic [DCW-1:0]   div_cnt_r;
  logic [RW-1:0]    rem_r, eff;
  logic [RW:0]      trial;
  logic [AW-1:0]    base_r;
  logic [SCW-1:0]   slot_r, rd_slot_r, hit_slot_r, free_slot_r;
  logic             rv_r, hit_r, free_r;
  logic [MW-1:0]    rd_r;
  logic             out_valid_r;
  bht_out_t         out_data_r, res;
  logic             wr_need, we;
  logic [AW-1:0]    wr_addr;
  logic [MW-1:0]    wr_data;

  // Bucket count of zero acts as one; values past the table size saturate.
  always_comb begin
    if (cfg_r == '0) begin
      eff = RW'(1);
    end else if (32'(cfg_r) > MAX_BUCKETS) begin
      eff = RW'(MAX_BUCKETS);
    end else begin
      eff = RW'(cfg_r);
    end
  end

  assign trial = {rem_r, ksh_r[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r      <= CFG_RESET;
      clr_addr_r <= '0;
    end else begin
      if (cfg_we) cfg_r <= cfg_data;
      if (cmd.clear_step) clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Restoring division, one key bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_data.command;
      key_r     <= in_data.key;
      ksh_r     <= in_data.key;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      ksh_r     <= {ksh_r[KEY_W-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + DCW'(1);
      if (trial >= {1'b0, eff}) begin
        rem_r <= RW'(trial - {1'b0, eff});
      end else begin
        rem_r <= trial[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.base_load) begin
      base_r <= AW'(32'(rem_r) * SLOTS_PER_BUCKET);
      slot_r <= '0;
    end else if (cmd.scan_step) begin
      slot_r <= slot_r + SCW'(1);
    end
  end

  // Read data arrives in the cycle after the slot is issued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_r      <= mem[base_r + AW'(slot_r)];
      rd_slot_r <= slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.base_load) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (rv_r) begin
      if (rd_r[MW-1]) begin
        if (!hit_r && rd_r[KEY_W-1:0] == key_r) begin
          hit_r      <= 1'b1;
          hit_slot_r <= rd_slot_r;
        end
      end else if (!free_r) begin
        free_r      <= 1'b1;
        free_slot_r <= rd_slot_r;
      end
    end
  end

  always_comb begin
    res.bucket_index = BUCKET_OUT_W'(rem_r);
    res.status       = STS_ABSENT;
    res.slot_index   = '0;
    wr_need          = 1'b0;
    wr_addr          = base_r + AW'(hit_slot_r);
    wr_data          = {1'b0, key_r};
    if (cmd_r == CMD_DELETE) begin
      if (hit_r) begin
        res.status     = STS_DELETED;
        res.slot_index = SLOT_OUT_W'(hit_slot_r);
        wr_need        = 1'b1;
      end
    end else if (hit_r) begin
      res.status     = STS_FOUND;
      res.slot_index = SLOT_OUT_W'(hit_slot_r);
    end else if (cmd_r == CMD_INSERT) begin
      if (free_r) begin
        res.status     = STS_INSERTED;
        res.slot_index = SLOT_OUT_W'(free_slot_r);
        wr_need        = 1'b1;
        wr_addr        = base_r + AW'(free_slot_r);
        wr_data        = {1'b1, key_r};
      end else begin
        res.status = STS_FULL;
      end
    end
  end

  assign we = cmd.clear_step || (cmd.finish && wr_need);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[cmd.clear_step ? clr_addr_r : wr_addr] <= cmd.clear_step ? '0 : wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign sts.clear_last = (clr_addr_r == AW'(ENTRIES - 1));
  assign sts.div_last   = (div_cnt_r == DCW'(KEY_W - 1));
  assign sts.scan_last  = (slot_r == SCW'(SLOTS_PER_BUCKET - 1));
  assign sts.out_busy   = out_valid_r && !out_ready;

  a_rv_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r |-> $past(cmd.scan_step)) else $error("read data valid without a scan step");
  a_finish_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r) else $error("result not presented after finish");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && !out_ready)) else $error("pending result overwritten");

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the bucketed hash table: directed rows, then random phases.
`timescale 1ns / 100ps

module tb_top;
  import bht_pkg::*;

  localparam int NUM_BUCKETS = DEF_MAX_BUCKETS;
  localparam int NUM_SLOTS   = DEF_SLOTS;
  localparam int NUM_ENTRIES = NUM_BUCKETS * NUM_SLOTS;
  localparam int POOL_SIZE   = 90;

  typedef struct {
    bht_in_t  item;
    bit       typed;
    bht_out_t result;
  } table_row_t;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  logic [CFG_W-1:0] cfg_data;
  logic     in_valid;
  logic     in_ready;
  bht_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bht_out_t out_data;

  // Shadow copy of the table contents and the bucket count register.
  logic [KEY_W-1:0] shadow_keys [NUM_ENTRIES];
  bit               shadow_active [NUM_ENTRIES];
  int               shadow_fill [NUM_BUCKETS];
  logic [CFG_W-1:0] shadow_buckets;

  bht_out_t   pending_results [$];
  table_row_t directed_rows [$];
  int         error_count;

  bucketed_hash_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Computes the result of one access and applies it to the shadow table.
  function automatic bht_out_t table_access(bht_in_t item);
    int       count;
    int       bucket;
    int       base;
    bit       hit;
    bit       have_free;
    int       hit_slot;
    int       free_slot;
    bht_out_t res;
    count = int'(shadow_buckets);
    if (count == 0) count = 1;
    if (count > NUM_BUCKETS) count = NUM_BUCKETS;
    bucket = int'({1'b0, item.key} % count);
    base = bucket * NUM_SLOTS;
    hit = 0;
    have_free = 0;
    hit_slot = 0;
    free_slot = 0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (shadow_active[base + s]) begin
        if (!hit && shadow_keys[base + s] == item.key) begin
          hit = 1;
          hit_slot = s;
        end
      end else if (!have_free) begin
        have_free = 1;
        free_slot = s;
      end
    end
    res.status = STS_ABSENT;
    res.bucket_index = bucket[BUCKET_OUT_W-1:0];
    res.slot_index = '0;
    if (item.command == CMD_DELETE) begin
      if (hit) begin
        shadow_active[base + hit_slot] = 0;
        if (shadow_fill[bucket] > 0) shadow_fill[bucket]--;
        res.status = STS_DELETED;
        res.slot_index = hit_slot[SLOT_OUT_W-1:0];
      end
    end else if (hit) begin
      res.status = STS_FOUND;
      res.slot_index = hit_slot[SLOT_OUT_W-1:0];
    end else if (item.command == CMD_INSERT) begin
      if (have_free) begin
        shadow_keys[base + free_slot] = item.key;
        shadow_active[base + free_slot] = 1;
        shadow_fill[bucket]++;
        res.status = STS_INSERTED;
        res.slot_index = free_slot[SLOT_OUT_W-1:0];
      end else begin
        res.status = STS_FULL;
      end
    end
    return res;
  endfunction

  task automatic add_row(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key, bit typed,
                         logic [STATUS_W-1:0] st, int bucket, int slot);
    table_row_t row;
    row.item.command = cmd;
    row.item.key = key;
    row.typed = typed;
    row.result.status = st;
    row.result.bucket_index = bucket[BUCKET_OUT_W-1:0];
    row.result.slot_index = slot[SLOT_OUT_W-1:0];
    directed_rows.push_back(row);
  endtask

  // Presents one item, waits for its transfer, then idles for the drawn gap.
  task automatic send_item(bht_in_t item, bit typed, bht_out_t typed_result, int gap);
    bht_out_t predicted;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predicted = table_access(item);
    pending_results.push_back(typed ? typed_result : predicted);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_bucket_count(logic [CFG_W-1:0] value);
    // Drop valid first so the last item is not presented a second time.
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_buckets = value;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] count, int n_items);
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    bht_in_t  item;
    bht_out_t none;
    int       pick;
    int       burst;
    none = '0;
    burst = 0;
    write_bucket_count(count);
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        item.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 50) item.command = CMD_INSERT;
        else if (pick < 75) item.command = CMD_LOOKUP;
        else if (pick < 95) item.command = CMD_DELETE;
        else item.command = CMD_SPARE;
      end else begin
        item.key = KEY_W'($urandom);
        item.command = CMD_W'($urandom_range(0, 3));
      end
      send_item(item, 1'b0, none, burst ? 0 : $urandom_range(0, 10));
    end
  endtask

  // Result side: stall draw per result, check against the oldest expectation.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  always @(posedge clk) begin
    bht_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d", $time,
                 out_data.status, out_data.bucket_index, out_data.slot_index);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   want.status, out_data.status);
          error_count++;
        end
        if (out_data.bucket_index !== want.bucket_index) begin
          $display("%0t: bucket mismatch: expected %0d, actual %0d", $time,
                   want.bucket_index, out_data.bucket_index);
          error_count++;
        end
        if (out_data.slot_index !== want.slot_index) begin
          $display("%0t: slot mismatch: expected %0d, actual %0d", $time,
                   want.slot_index, out_data.slot_index);
          error_count++;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("** bucketed_hash_table: FAILED **");
    $finish;
  end

  initial begin
    error_count = 0;
    shadow_buckets = CFG_RESET;
    foreach (shadow_active[i]) begin
      shadow_active[i] = 0;
      shadow_keys[i] = '0;
    end
    foreach (shadow_fill[i]) shadow_fill[i] = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset count of 256: results follow directly from the key's low byte.
    add_row(CMD_LOOKUP, 31'd0, 1, STS_ABSENT, 0, 0);
    add_row(CMD_INSERT, 31'd0, 1, STS_INSERTED, 0, 0);
    add_row(CMD_LOOKUP, 31'd0, 1, STS_FOUND, 0, 0);
    add_row(CMD_INSERT, 31'h7FFFFFFF, 1, STS_INSERTED, 255, 0);
    add_row(CMD_INSERT, 31'h7FFFFFFF, 1, STS_FOUND, 255, 0);
    add_row(CMD_DELETE, 31'h7FFFFFFF, 1, STS_DELETED, 255, 0);
    add_row(CMD_DELETE, 31'h7FFFFFFF, 1, STS_ABSENT, 255, 0);
    add_row(CMD_SPARE, 31'd0, 1, STS_FOUND, 0, 0);
    add_row(CMD_SPARE, 31'd256, 1, STS_ABSENT, 0, 0);
    add_row(CMD_INSERT, 31'd256, 1, STS_INSERTED, 0, 1);
    add_row(CMD_INSERT, 31'h55555555, 0, STS_FOUND, 0, 0);
    add_row(CMD_INSERT, 31'h2AAAAAAA, 0, STS_FOUND, 0, 0);
    add_row(CMD_DELETE, 31'd0, 1, STS_DELETED, 0, 0);
    add_row(CMD_INSERT, 31'd512, 1, STS_INSERTED, 0, 0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result,
                $urandom_range(0, 10));

    // Zero, oversized, small and mid-size bucket counts in turn; the smallest tables fill up.
    run_phase(9'd0, 160);
    run_phase(9'd511, 150);
    run_phase(9'd1, 250);
    run_phase(9'd300, 150);
    run_phase(9'd2, 250);
    run_phase(9'd256, 200);
    run_phase(9'd5, 250);
    run_phase(9'd128, 150);
    run_phase(9'd1, 160);

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (120) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("** bucketed_hash_table: PASSED **");
    end else begin
      $display("** bucketed_hash_table: FAILED **");
    end
    $finish;
  end

endmodule
